// ===== hw/rtl/nwd_pkg.sv =====
`timescale 1ns / 1ps
package nwd_pkg;
	localparam int MaxWalls = 1024;
	localparam int AddrW = $clog2(MaxWalls);
	localparam int CntW = AddrW + 1;
	localparam int CoordW = 24;
	localparam int DistW = 26;
	localparam int SqW = 51;
	localparam logic [DistW-1:0] DistMax = '1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic load;
		logic rd_en;
		logic acc_init;
		logic acc_en;
		logic sqrt_start;
		logic sqrt_step;
		logic out_load;
	} nwd_ctl_t;

	// datapath to controller
	typedef struct packed {
		logic [CntW-1:0] count;
		logic sqrt_done;
	} nwd_sts_t;
endpackage

// ===== hw/rtl/nwd_if.sv =====
`timescale 1ns / 1ps
interface nwd_in_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic signed [nwd_pkg::CoordW-1:0] x;
	logic signed [nwd_pkg::CoordW-1:0] y;
	logic signed [nwd_pkg::CoordW-1:0] z;
	logic wall_adjacent;
	logic [nwd_pkg::DistW-1:0] normal_distance;
	modport source (output valid, cmd, x, y, z, wall_adjacent, normal_distance, input ready);
	modport sink (input valid, cmd, x, y, z, wall_adjacent, normal_distance, output ready);
endinterface

interface nwd_out_if;
	logic valid;
	logic ready;
	logic [nwd_pkg::DistW-1:0] distance;
	logic no_walls;
	logic overflowed;
	modport source (output valid, distance, no_walls, overflowed, input ready);
	modport sink (input valid, distance, no_walls, overflowed, output ready);
endinterface

// ===== hw/rtl/nwd_ctrl.sv =====
`timescale 1ns / 1ps
module nwd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [1:0] in_cmd,
	output logic in_ready,
	input  logic out_valid,
	input  logic out_ready,
	input  nwd_pkg::nwd_sts_t sts,
	output nwd_pkg::nwd_ctl_t ctl
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_DRAIN = 5'b00100,
		S_SQRT = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	logic [nwd_pkg::CntW-1:0] idx_q;
	logic [1:0] drain_q;
	logic acc_q;
	logic accept;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	// command decode and sequencing
	always_comb begin
		ctl = '0;
		ctl.capture = accept;
		ctl.clear = accept && (in_cmd == nwd_pkg::CMD_CLEAR);
		ctl.load = accept && (in_cmd == nwd_pkg::CMD_LOAD);
		ctl.acc_init = accept && (in_cmd == nwd_pkg::CMD_QUERY);
		ctl.rd_en = (state_q == S_SCAN);
		ctl.acc_en = acc_q;
		ctl.sqrt_start = (state_q == S_DRAIN) && (drain_q == 2'd0) && !acc_q;
		ctl.sqrt_step = (state_q == S_SQRT);
		ctl.out_load = (state_q == S_DONE) && (!out_valid || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			drain_q <= '0;
			acc_q <= 1'b0;
		end else begin
			// read data returns in the next cycle, then the difference and square stages
			acc_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && in_cmd == nwd_pkg::CMD_QUERY) begin
						idx_q <= '0;
						state_q <= (sts.count == '0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q + 1'b1 == sts.count) begin
						state_q <= S_DRAIN;
						drain_q <= 2'd3;
					end
				end
				S_DRAIN: begin
					if (drain_q == 2'd0) state_q <= S_SQRT;
					else drain_q <= drain_q - 1'b1;
				end
				S_SQRT: begin
					if (sts.sqrt_done) state_q <= S_DONE;
				end
				S_DONE: begin
					if (ctl.out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/nwd_dp.sv =====
`timescale 1ns / 1ps
module nwd_dp (
	input  logic clk,
	input  logic arst_n,
	input  nwd_pkg::nwd_ctl_t ctl,
	output nwd_pkg::nwd_sts_t sts,
	input  logic signed [nwd_pkg::CoordW-1:0] x,
	input  logic signed [nwd_pkg::CoordW-1:0] y,
	input  logic signed [nwd_pkg::CoordW-1:0] z,
	input  logic wall_adjacent,
	input  logic [nwd_pkg::DistW-1:0] normal_distance,
	output logic [nwd_pkg::DistW-1:0] res_distance,
	output logic res_no_walls,
	output logic res_overflowed
);
	localparam int CW = nwd_pkg::CoordW;
	localparam int AW = nwd_pkg::AddrW;
	localparam int SW = nwd_pkg::SqW;

	logic [3*CW-1:0] mem [nwd_pkg::MaxWalls];
	logic [3*CW-1:0] rd_s1;
	logic [nwd_pkg::CntW-1:0] count_q, rd_idx_q;
	logic ovf_q;
	logic signed [CW-1:0] qx_q, qy_q, qz_q;
	logic adj_q;
	logic [nwd_pkg::DistW-1:0] cap_q;
	logic v_s1, v_s2, v_s3;
	logic signed [CW:0] dx_s2, dy_s2, dz_s2;
	logic [2*CW-1:0] sx_s3, sy_s3, sz_s3;
	logic [SW-1:0] best_q;
	logic [SW-1:0] sum;
	logic [SW+1:0] rem_q;
	logic [nwd_pkg::DistW-1:0] root_q;
	logic [4:0] step_q;
	logic [SW+1:0] trial;
	logic [SW+1:0] pre_rem;
	logic [nwd_pkg::DistW-1:0] dist_cap;

	// bit pair of the minimum at position p
	function automatic logic [1:0] best_ext(input logic [5:0] p);
		logic [51:0] b;
		b = {1'b0, best_q};
		return b[p+:2];
	endfunction

	// pair brought down for the step after step s
	function automatic logic [1:0] best_bits(input logic [4:0] s);
		logic [1:0] r;
		r = 2'b00;
		if (s > 5'd1) r = best_ext(6'(2*(s-5'd2)));
		return r;
	endfunction

	// wall store and counters
	always_ff @(posedge clk) begin
		if (ctl.load && count_q < nwd_pkg::CntW'(nwd_pkg::MaxWalls))
			mem[count_q[AW-1:0]] <= {x, y, z};
		if (ctl.rd_en) rd_s1 <= mem[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q <= 1'b0;
			rd_idx_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ctl.clear) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end else if (ctl.load) begin
				if (count_q < nwd_pkg::CntW'(nwd_pkg::MaxWalls)) count_q <= count_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (ctl.acc_init) rd_idx_q <= '0;
			else if (ctl.rd_en) rd_idx_q <= rd_idx_q + 1'b1;
			v_s1 <= ctl.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// query capture
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			qx_q <= x;
			qy_q <= y;
			qz_q <= z;
			adj_q <= wall_adjacent;
			cap_q <= normal_distance;
		end
	end

	// difference, square, then running minimum
	assign sum = SW'(sx_s3) + SW'(sy_s3) + SW'(sz_s3);
	always_ff @(posedge clk) begin
		dx_s2 <= (CW+1)'(qx_q) - (CW+1)'($signed(rd_s1[3*CW-1:2*CW]));
		dy_s2 <= (CW+1)'(qy_q) - (CW+1)'($signed(rd_s1[2*CW-1:CW]));
		dz_s2 <= (CW+1)'(qz_q) - (CW+1)'($signed(rd_s1[CW-1:0]));
		sx_s3 <= (2*CW)'($unsigned((2*CW+2)'(dx_s2) * (2*CW+2)'(dx_s2)));
		sy_s3 <= (2*CW)'($unsigned((2*CW+2)'(dy_s2) * (2*CW+2)'(dy_s2)));
		sz_s3 <= (2*CW)'($unsigned((2*CW+2)'(dz_s2) * (2*CW+2)'(dz_s2)));
		if (ctl.acc_init) best_q <= '1;
		else if (v_s3 && sum < best_q) best_q <= sum;
	end

	// top pair of the minimum seeds the remainder
	always_comb begin
		pre_rem = (SW+2)'(best_ext(6'd50));
	end

	// restoring square root, one result bit per cycle
	assign trial = rem_q - {root_q, 2'b01};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (ctl.sqrt_start) begin
			step_q <= 5'd26;
		end else if (ctl.sqrt_step && step_q != '0) begin
			step_q <= step_q - 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.sqrt_start) begin
			rem_q <= pre_rem;
			root_q <= '0;
		end else if (ctl.sqrt_step && step_q != '0) begin
			if (!trial[SW+1] || rem_q >= {root_q, 2'b01}) begin
				rem_q <= {trial[SW-1:0], 2'b00} | (SW+2)'(best_bits(step_q));
				root_q <= {root_q[nwd_pkg::DistW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[SW-1:0], 2'b00} | (SW+2)'(best_bits(step_q));
				root_q <= {root_q[nwd_pkg::DistW-2:0], 1'b0};
			end
		end
	end

	assign sts.count = count_q;
	assign sts.sqrt_done = (step_q == 5'd1) && ctl.sqrt_step;

	// final root, empty saturation and normal cap
	always_comb begin
		dist_cap = (count_q == '0) ? nwd_pkg::DistMax : root_q;
		if (adj_q && cap_q < dist_cap) dist_cap = cap_q;
	end
	assign res_distance = dist_cap;
	assign res_no_walls = (count_q == '0);
	assign res_overflowed = ovf_q;
endmodule

// ===== hw/rtl/nearest_wall_distance.sv =====
`timescale 1ns / 1ps
// Query: scan one wall per cycle from the store read port, then a pipeline
// drain, then a 26-step bit-serial square root, then the result is loaded.
// Empty-store query: goes straight to the result. Load, clear and unknown commands: done on accept.
// One item at a time; the next item is taken once the result register frees.
// arst_n clears the wall count, overflow flag and all control state.
module nearest_wall_distance (
	input logic clk,
	input logic arst_n,
	nwd_in_if.sink in_ch,
	nwd_out_if.source out_ch
);
	nwd_pkg::nwd_ctl_t ctl;
	nwd_pkg::nwd_sts_t sts;
	logic [nwd_pkg::DistW-1:0] r_dist;
	logic r_nw, r_ov;
	logic out_valid_q;

	nwd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_cmd(in_ch.cmd), .in_ready(in_ch.ready),
		.out_valid(out_valid_q), .out_ready(out_ch.ready),
		.sts(sts), .ctl(ctl)
	);

	nwd_dp u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.x(in_ch.x), .y(in_ch.y), .z(in_ch.z),
		.wall_adjacent(in_ch.wall_adjacent), .normal_distance(in_ch.normal_distance),
		.res_distance(r_dist), .res_no_walls(r_nw), .res_overflowed(r_ov)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			out_ch.distance <= r_dist;
			out_ch.no_walls <= r_nw;
			out_ch.overflowed <= r_ov;
		end
	end
	assign out_ch.valid = out_valid_q;
endmodule

// ===== test/nearest_wall_distance_tb.sv =====
`timescale 1ns / 1ps
module nearest_wall_distance_tb;
	import nwd_pkg::*;

	logic clk;
	logic arst_n;
	nwd_in_if in_ch();
	nwd_out_if out_ch();

	nearest_wall_distance uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	typedef struct packed {
		logic [DistW-1:0] distance;
		logic no_walls;
		logic overflowed;
	} dist_word_t;

	typedef struct {
		cmd_t cmd;
		logic signed [CoordW-1:0] x, y, z;
		logic adj;
		logic [DistW-1:0] cap;
		logic has_lit;
		dist_word_t lit;
	} stim_row_t;

	// shadow wall store
	logic signed [CoordW-1:0] wx [MaxWalls];
	logic signed [CoordW-1:0] wy [MaxWalls];
	logic signed [CoordW-1:0] wz [MaxWalls];
	int wall_cnt;
	logic ovf;

	dist_word_t expected_dist[$];
	int err_count;
	int idle_cnt;
	int send_idle_pct, recv_idle_pct;
	bit hold_recv;
	bit stim_done;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic logic [31:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r[31:0];
	endfunction

	// update the shadow store; returns 1 and the word when a query answers
	function automatic bit predict_wall_dist(input stim_row_t s, output dist_word_t w);
		logic [63:0] best, d, res_d;
		longint dx, dy, dz;
		w = '0;
		case (s.cmd)
			CMD_CLEAR: begin
				wall_cnt = 0;
				ovf = 0;
			end
			CMD_LOAD: begin
				if (wall_cnt < MaxWalls) begin
					wx[wall_cnt] = s.x;
					wy[wall_cnt] = s.y;
					wz[wall_cnt] = s.z;
					wall_cnt++;
				end else begin
					ovf = 1;
				end
			end
			CMD_QUERY: begin
				if (wall_cnt == 0) begin
					res_d = DistMax;
				end else begin
					best = '1;
					for (int j = 0; j < wall_cnt; j++) begin
						dx = longint'(s.x) - longint'(wx[j]);
						dy = longint'(s.y) - longint'(wy[j]);
						dz = longint'(s.z) - longint'(wz[j]);
						d = dx * dx + dy * dy + dz * dz;
						if (d < best) best = d;
					end
					res_d = root_floor(best);
					if (res_d > DistMax) res_d = DistMax;
				end
				if (s.adj && s.cap < res_d) res_d = s.cap;
				w.distance = res_d[DistW-1:0];
				w.no_walls = (wall_cnt == 0);
				w.overflowed = ovf;
				return 1;
			end
			default: ;
		endcase
		return 0;
	endfunction

	// valid stays up after a handshake until the next word or an idle cycle
	task automatic send_word(input stim_row_t s);
		dist_word_t w;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= s.cmd;
		in_ch.x <= s.x;
		in_ch.y <= s.y;
		in_ch.z <= s.z;
		in_ch.wall_adjacent <= s.adj;
		in_ch.normal_distance <= s.cap;
		do @(posedge clk); while (!in_ch.ready);
		if (predict_wall_dist(s, w)) begin
			if (s.has_lit && w !== s.lit)
				report("directed row vs predictor", w, s.lit);
			expected_dist = {expected_dist, w};
		end
	endtask

	function automatic stim_row_t mk(input cmd_t c, input int x, input int y, input int z,
			input logic adj, input logic [DistW-1:0] cap);
		stim_row_t s;
		s.cmd = c;
		s.x = CoordW'(x);
		s.y = CoordW'(y);
		s.z = CoordW'(z);
		s.adj = adj;
		s.cap = cap;
		s.has_lit = 0;
		s.lit = '0;
		return s;
	endfunction

	function automatic stim_row_t lit(input stim_row_t s, input logic [DistW-1:0] d,
			input logic nw, input logic ov);
		s.has_lit = 1;
		s.lit = '{distance: d, no_walls: nw, overflowed: ov};
		return s;
	endfunction

	function automatic logic signed [CoordW-1:0] rnd_coord();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
			1: return CoordW'($urandom_range(8191)) - 24'sd4096;
			default: return CoordW'($urandom());
		endcase
	endfunction

	function automatic stim_row_t rnd_row(input cmd_t c);
		return mk(c, rnd_coord(), rnd_coord(), rnd_coord(), 1'($urandom_range(1)),
			$urandom_range(3) == 0 ? DistW'($urandom()) : DistW'($urandom_range(1 << 16)));
	endfunction

	// result side: random stall plus one long hold-off
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (expected_dist.size() == 0) begin
				report("result with nothing expected", out_ch.distance, 0);
			end else begin
				dist_word_t e;
				e = expected_dist.pop_front();
				if (out_ch.distance !== e.distance)
					report("distance", out_ch.distance, e.distance);
				if (out_ch.no_walls !== e.no_walls)
					report("no_walls", out_ch.no_walls, e.no_walls);
				if (out_ch.overflowed !== e.overflowed)
					report("overflowed", out_ch.overflowed, e.overflowed);
			end
		end
		out_ch.ready <= !hold_recv && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	// watchdog on handshake silence
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt > 200000) begin
			$display("nearest_wall_distance_tb: errors");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		stim_row_t s;
		int n, waited;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.cmd = CMD_CLEAR;
		in_ch.x = 0;
		in_ch.y = 0;
		in_ch.z = 0;
		in_ch.wall_adjacent = 0;
		in_ch.normal_distance = 0;
		out_ch.ready = 0;
		hold_recv = 0;
		err_count = 0;
		idle_cnt = 0;
		wall_cnt = 0;
		ovf = 0;
		send_idle_pct = 19;
		recv_idle_pct = 64;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table
		rows = {rows, lit(mk(CMD_QUERY, 0, 0, 0, 0, 0), DistMax, 1, 0)};
		rows = {rows, lit(mk(CMD_QUERY, 5, 5, 5, 1, 26'd1234), 26'd1234, 1, 0)};
		rows = {rows, mk(CMD_NONE, 1, 2, 3, 1, 0)};
		rows = {rows, mk(CMD_LOAD, 0, 0, 0, 1, 26'h3ffffff)};
		rows = {rows, lit(mk(CMD_QUERY, 0, 0, 0, 0, 0), 0, 0, 0)};
		rows = {rows, lit(mk(CMD_QUERY, 4096, 0, 0, 0, 0), 26'd4096, 0, 0)};
		rows = {rows, lit(mk(CMD_QUERY, 0, 0, 3 * 4096, 1, 26'd100), 26'd100, 0, 0)};
		rows = {rows, lit(mk(CMD_QUERY, 0, 4096, 0, 1, 26'h3ffffff), 26'd4096, 0, 0)};
		rows = {rows, mk(CMD_CLEAR, -1, -1, -1, 1, 26'h3ffffff)};
		rows = {rows, lit(mk(CMD_QUERY, 0, 0, 0, 0, 0), DistMax, 1, 0)};
		rows = {rows, mk(CMD_LOAD, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 0, 0)};
		rows = {rows, mk(CMD_QUERY, 24'sh800000, 24'sh800000, 24'sh800000, 0, 0)};
		rows = {rows, mk(CMD_QUERY, 24'sh800000, 24'sh800000, 24'sh800000, 1, 26'h3ffffff)};
		rows = {rows, mk(CMD_LOAD, 24'sh800000, 24'sh800000, 24'sh800000, 0, 0)};
		rows = {rows, mk(CMD_LOAD, 8, -8, 8, 0, 0)};
		rows = {rows, mk(CMD_LOAD, -8, 8, -8, 0, 0)};
		rows = {rows, mk(CMD_QUERY, 0, 0, 0, 0, 0)};
		rows = {rows, mk(CMD_QUERY, 24'sh7fffff, 24'sh800000, 24'sh7fffff, 0, 0)};
		foreach (rows[i]) send_word(rows[i]);

		// clear, then an empty query with the cap left open
		send_word(mk(CMD_CLEAR, 0, 0, 0, 0, 0));
		send_word(lit(mk(CMD_QUERY, 0, 0, 0, 1, 26'h3ffffff), DistMax, 1, 0));

		// random: small wall sets with queries, some noise; three idling phases
		n = 0;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = ph == 0 ? 19 : ph == 1 ? 64 : 0;
			recv_idle_pct = ph == 0 ? 64 : ph == 1 ? 19 : 0;
			if (ph == 2) begin
				fork
					begin
						hold_recv = 1;
						repeat (3000) @(posedge clk);
						hold_recv = 0;
					end
				join_none
			end
			for (int k = 0; k < 180; k++) begin
				case ($urandom_range(19))
					0: send_word(rnd_row(CMD_CLEAR));
					1: send_word(rnd_row(CMD_NONE));
					2, 3, 4, 5, 6, 7: send_word(rnd_row(CMD_LOAD));
					default: send_word(rnd_row(CMD_QUERY));
				endcase
				if (wall_cnt > 40) send_word(rnd_row(CMD_CLEAR));
			end
		end
		in_ch.valid <= 1'b0;

		waited = 0;
		while (expected_dist.size() != 0 && waited < 500000) begin
			@(posedge clk);
			waited++;
		end
		repeat (MaxWalls + 100) @(posedge clk);
		if (err_count == 0 && expected_dist.size() == 0)
			$display("nearest_wall_distance_tb: clean");
		else
			$display("nearest_wall_distance_tb: errors");
		$finish;
	end
endmodule
